// ===== rtl/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// Prime sieve package
// Sizes, derived widths and the control bundle shared by the sieve cells.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int NUM_STAGES  = 32;
    localparam int VALUE_WIDTH = 16;

    // Stream word width: the value rounded up to whole bytes.
    localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    // The step counter covers both the divide phase and the sweep phase.
    localparam int STEP_MAX = (NUM_STAGES > VALUE_WIDTH) ? NUM_STAGES : VALUE_WIDTH;
    localparam int CNT_W    = $clog2(STEP_MAX + 1);

    typedef struct packed {
        logic                   load;
        logic                   step;
        logic                   bit_in;
        logic                   sweep;
        logic                   store;
        logic [VALUE_WIDTH-1:0] value;
    } sps_ctrl_t;

endpackage

// ===== rtl/streaming_prime_sieve_unit.sv =====
// ----------------------------------------------------------------------------
// Streaming prime sieve
// Drops candidates divided by a stored prime; emits survivors, stores if room.
// ----------------------------------------------------------------------------
// Usage:
// Candidates arrive on the s_ channel, one per word, normally ascending from 2.
// Each candidate is tested against every stored prime in a row of cells. A
// candidate that no stored prime divides is sent on the m_ channel and stored
// in the first empty cell; when every cell is occupied it is still sent, with
// m_tuser set, and not stored. Divided candidates produce no word.
// One candidate is processed at a time: a bit-serial remainder is worked out
// in all cells at once, then the drop flag ripples down the cell row, and a
// final state hands on the result; a new word is taken only once that state
// is left and the unit is idle again.
// The result sits in an output register; a stalled receiver holds it there
// while the next candidate is already being tested, and a finished survivor
// waits until the register is free. Reset empties every cell and the output.
// ----------------------------------------------------------------------------
module streaming_prime_sieve_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [sps_pkg::DATA_W-1:0] s_tdata,   // candidate
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [sps_pkg::DATA_W-1:0] m_tdata,   // prime_value
    output logic                      m_tuser     // chain_full
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [sps_pkg::CNT_W-1:0] DIV_LAST   =
        sps_pkg::CNT_W'(sps_pkg::VALUE_WIDTH - 1);
    localparam logic [sps_pkg::CNT_W-1:0] SWEEP_LAST =
        sps_pkg::CNT_W'(sps_pkg::NUM_STAGES - 1);

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [sps_pkg::CNT_W-1:0]       cnt_reg;
    logic [sps_pkg::CNT_W-1:0]       cnt_next;
    logic [sps_pkg::VALUE_WIDTH-1:0] cand_reg;
    logic [sps_pkg::VALUE_WIDTH-1:0] shift_reg;
    logic                            m_tvalid_reg;
    logic                            m_tvalid_next;
    logic [sps_pkg::DATA_W-1:0]      m_tdata_reg;
    logic                            m_tuser_reg;

    logic                            s_accept;
    logic                            out_free;
    logic                            emit;
    logic                            chain_hit;
    logic                            chain_full;
    sps_pkg::sps_ctrl_t              ctrl;

    logic [sps_pkg::NUM_STAGES:0]    used_chain;
    logic [sps_pkg::NUM_STAGES:0]    hit_chain;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign chain_hit  = hit_chain[sps_pkg::NUM_STAGES];
    assign chain_full = used_chain[sps_pkg::NUM_STAGES];
    assign emit       = (state_reg == ST_DONE) && !chain_hit && out_free;

    assign ctrl.load   = s_accept;
    assign ctrl.step   = (state_reg == ST_DIV);
    assign ctrl.bit_in = shift_reg[sps_pkg::VALUE_WIDTH-1];
    assign ctrl.sweep  = (state_reg == ST_SWEEP);
    assign ctrl.store  = emit;
    assign ctrl.value  = cand_reg;

    assign used_chain[0] = 1'b1;
    assign hit_chain[0]  = 1'b0;

    for (genvar i = 0; i < sps_pkg::NUM_STAGES; i++) begin : g_cell
        sps_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .prev_used (used_chain[i]),
            .hit_in    (hit_chain[i]),
            .used_out  (used_chain[i+1]),
            .hit_out   (hit_chain[i+1])
        );
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_SWEEP;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + sps_pkg::CNT_W'(1);
                end
            end
            ST_SWEEP: begin
                if (cnt_reg == SWEEP_LAST) begin
                    state_next = ST_DONE;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + sps_pkg::CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (chain_hit || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cand_reg  <= s_tdata[sps_pkg::VALUE_WIDTH-1:0];
            shift_reg <= s_tdata[sps_pkg::VALUE_WIDTH-1:0];
        end else if (ctrl.step) begin
            shift_reg <= shift_reg << 1;
        end
        if (emit) begin
            m_tdata_reg <= sps_pkg::DATA_W'(cand_reg);
            m_tuser_reg <= chain_full;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/sps_cell.sv =====
// ----------------------------------------------------------------------------
// Prime sieve cell
// Holds one stored prime and a bit-serial remainder of the current candidate,
// and passes its occupied flag and the running drop flag to the next cell.
// ----------------------------------------------------------------------------
module sps_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  sps_pkg::sps_ctrl_t ctrl,
    input  logic              prev_used,
    input  logic              hit_in,
    output logic              used_out,
    output logic              hit_out
);

    logic                            used_reg;
    logic                            used_next;
    logic [sps_pkg::VALUE_WIDTH-1:0] prime_reg;
    logic [sps_pkg::VALUE_WIDTH-1:0] rem_reg;
    logic [sps_pkg::VALUE_WIDTH-1:0] rem_next;
    logic                            hit_reg;
    logic                            hit_next;
    logic [sps_pkg::VALUE_WIDTH:0]   shifted;
    logic [sps_pkg::VALUE_WIDTH:0]   divisor;
    logic                            drop;
    logic                            take;

    assign shifted = {rem_reg, ctrl.bit_in};
    assign divisor = {1'b0, prime_reg};
    assign take    = ctrl.store && !used_reg && prev_used;
    assign drop    = ctrl.sweep && used_reg && (prime_reg != '0) && (rem_reg == '0);

    always_comb begin
        rem_next = rem_reg;
        if (ctrl.load) begin
            rem_next = '0;
        end else if (ctrl.step) begin
            if (shifted >= divisor) begin
                rem_next = sps_pkg::VALUE_WIDTH'(shifted - divisor);
            end else begin
                rem_next = sps_pkg::VALUE_WIDTH'(shifted);
            end
        end
    end

    always_comb begin
        hit_next = hit_reg;
        if (ctrl.load) begin
            hit_next = 1'b0;
        end else if (ctrl.sweep) begin
            hit_next = hit_in || drop;
        end
    end

    assign used_next = used_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end else begin
            used_reg <= used_next;
            hit_reg  <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        if (take) begin
            prime_reg <= ctrl.value;
        end
    end

    assign used_out = used_reg;
    assign hit_out  = hit_reg;

`ifndef SYNTHESIS
    a_used_sticky : assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg |=> used_reg)
        else $error("occupied cell was released");

    a_used_contiguous : assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg |-> prev_used)
        else $error("occupied cell follows an empty cell");

    a_rem_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.sweep && used_reg && (prime_reg != '0)) |-> (rem_reg < prime_reg))
        else $error("remainder not below stored prime");
`endif

endmodule
